[rtl/core/wsfr_pkg.sv]
// shared types and constants of the websocket frame receiver and unmasker
`default_nettype none

package wsfr_pkg;

   localparam int LENGTH_COUNTER_BITS = 64;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;

   localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [6:0] LEN_EXT64      = 7'd127;

   localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
   localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
   localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_HDR0   = 7'b0000001,
      PH_HDR1   = 7'b0000010,
      PH_EXT    = 7'b0000100,
      PH_KEY    = 7'b0001000,
      PH_TEXT   = 7'b0010000,
      PH_SKIP   = 7'b0100000,
      PH_CLOSED = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/websocket_frame_receiver_unmasker.sv]
// top level of the websocket frame receiver and unmasker
//
// channel   direction  word
// req_      in         rx_byte
// rsp_      out        kind, payload_byte, frame_opcode, last
//
// one byte is accepted every cycle while req_ready is high, and a result
// appears on rsp_ the cycle after its byte is taken if no result waits.
// a two-entry result buffer keeps req_ready high while one result waits;
// req_ready drops only when both entries are full.
// synchronous reset returns the parser to waiting for a frame header.
`default_nettype none

module websocket_frame_receiver_unmasker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_last
);

   logic                 accept;
   logic                 res_valid;
   wsfr_pkg::result_type res_word;
   wsfr_pkg::result_type out_word;

   assign accept = req_valid & req_ready;

   wsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   wsfr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .has_space (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_kind = out_word.kind;
   assign rsp_payload_byte = out_word.payload_byte;
   assign rsp_frame_opcode = out_word.frame_opcode;
   assign rsp_last = out_word.last;

endmodule

`default_nettype wire

[rtl/core/wsfr_parser.sv]
// frame header parser, length counter and payload unmasking
`default_nettype none

module wsfr_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_accept,
   input  wire logic [7:0]            in_byte,
   output logic                       res_valid,
   output wsfr_pkg::result_type       res_word
);

   localparam int LB = wsfr_pkg::LENGTH_COUNTER_BITS;

   wsfr_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          opcode_ff, opcode_in;
   logic                mask_ff, mask_in;
   logic [LB-1:0]       rem_ff, rem_in;
   logic [2:0]          count_ff, count_in;
   logic [31:0]         key_ff, key_in;
   logic [1:0]          index_ff, index_in;

   logic       len_done;
   logic       hdr_done;
   logic       res_v;
   logic [6:0] len7;
   logic [7:0] key_byte;

   assign len7 = in_byte[6:0];

   always_comb begin
      case (index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      opcode_in = opcode_ff;
      mask_in = mask_ff;
      rem_in = rem_ff;
      count_in = count_ff;
      key_in = key_ff;
      index_in = index_ff;
      len_done = 1'b0;
      hdr_done = 1'b0;
      res_v = 1'b0;
      res_word.kind = wsfr_pkg::KIND_BYTE;
      res_word.payload_byte = 8'h00;
      res_word.frame_opcode = opcode_ff;
      res_word.last = 1'b0;

      unique case (phase_ff)
         wsfr_pkg::PH_HDR0: begin
            opcode_in = in_byte[3:0];
            phase_in = wsfr_pkg::PH_HDR1;
         end
         wsfr_pkg::PH_HDR1: begin
            mask_in = in_byte[7];
            key_in = 32'h0;
            if (len7 <= wsfr_pkg::LEN_DIRECT_MAX) begin
               rem_in = {{(LB-7){1'b0}}, len7};
               len_done = 1'b1;
            end else begin
               rem_in = '0;
               count_in = (len7 == wsfr_pkg::LEN_EXT16) ? wsfr_pkg::EXT16_BYTES_M1
                                                       : wsfr_pkg::EXT64_BYTES_M1;
               phase_in = wsfr_pkg::PH_EXT;
            end
         end
         wsfr_pkg::PH_EXT: begin
            rem_in = {rem_ff[LB-9:0], in_byte};
            if (count_ff == 3'd0) begin
               len_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         wsfr_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], in_byte};
            if (count_ff == 3'd0) begin
               hdr_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         wsfr_pkg::PH_TEXT: begin
            index_in = index_ff + 2'd1;
            rem_in = rem_ff - {{(LB-1){1'b0}}, 1'b1};
            res_v = 1'b1;
            res_word.kind = wsfr_pkg::KIND_BYTE;
            res_word.payload_byte = in_byte ^ key_byte;
            if (rem_in == '0) begin
               phase_in = wsfr_pkg::PH_HDR0;
               res_word.last = 1'b1;
            end
         end
         wsfr_pkg::PH_SKIP: begin
            rem_in = rem_ff - {{(LB-1){1'b0}}, 1'b1};
            if (rem_in == '0) begin
               phase_in = wsfr_pkg::PH_HDR0;
            end
         end
         wsfr_pkg::PH_CLOSED: begin
         end
         default: begin
            phase_in = wsfr_pkg::PH_HDR0;
         end
      endcase

      // length field finished: mask key next, or header complete
      if (len_done) begin
         if (mask_in) begin
            count_in = wsfr_pkg::KEY_BYTES_M1;
            key_in = 32'h0;
            phase_in = wsfr_pkg::PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         index_in = 2'd0;
         if (opcode_ff == wsfr_pkg::OP_TEXT) begin
            if (rem_in == '0) begin
               phase_in = wsfr_pkg::PH_HDR0;
               res_v = 1'b1;
               res_word.kind = wsfr_pkg::KIND_EMPTY;
               res_word.last = 1'b1;
            end else begin
               phase_in = wsfr_pkg::PH_TEXT;
            end
         end else if (opcode_ff == wsfr_pkg::OP_CLOSE) begin
            phase_in = wsfr_pkg::PH_CLOSED;
            res_v = 1'b1;
            res_word.kind = wsfr_pkg::KIND_CLOSE;
            res_word.last = 1'b1;
         end else begin
            phase_in = (rem_in == '0) ? wsfr_pkg::PH_HDR0 : wsfr_pkg::PH_SKIP;
            res_v = 1'b1;
            res_word.kind = wsfr_pkg::KIND_OTHER;
            res_word.last = 1'b1;
         end
      end
   end

   assign res_valid = in_accept & res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfr_pkg::PH_HDR0;
         opcode_ff <= 4'h0;
         mask_ff <= 1'b0;
         rem_ff <= '0;
         count_ff <= 3'd0;
         key_ff <= 32'h0;
         index_ff <= 2'd0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff <= mask_in;
         rem_ff <= rem_in;
         count_ff <= count_in;
         key_ff <= key_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/wsfr_rsp_fifo.sv]
// two-entry result buffer between parser and result channel
`default_nettype none

module wsfr_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wsfr_pkg::result_type  push_word,
   output logic                       has_space,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output wsfr_pkg::result_type       out_word
);

   wsfr_pkg::result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, wr_ff;
   logic       pop;

   assign has_space = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word = entry_ff[rd_ff];
   assign pop = out_valid & out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

endmodule

`default_nettype wire

[verif/websocket_frame_receiver_unmasker_test.sv]
// self-checking testbench of the websocket frame receiver and unmasker
`timescale 1ns / 1ps

module websocket_frame_receiver_unmasker_test;

   localparam int LB           = wsfr_pkg::LENGTH_COUNTER_BITS;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 60;

   typedef enum int {
      LEN_FORM_DIRECT,
      LEN_FORM_EXT16,
      LEN_FORM_EXT64
   } len_form_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_last;

   // expected parser state
   wsfr_pkg::phase_type rx_phase       = wsfr_pkg::PH_HDR0;
   logic [3:0]          rx_opcode      = '0;
   logic                rx_masked      = 1'b0;
   logic [LB-1:0]       rx_remaining   = '0;
   logic [2:0]          rx_field_count = '0;
   logic [31:0]         rx_key         = '0;
   logic [1:0]          rx_key_index   = '0;

   wsfr_pkg::result_type expected_results[$];
   int         error_count  = 0;
   int         bytes_sent   = 0;
   int         quiet_cycles = 0;
   int         stall_left   = 0;
   int         hold_left    = 0;
   bit         idle_on      = 1'b1;
   bit         hold_request = 1'b0;

   websocket_frame_receiver_unmasker i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void queue_result(input wsfr_pkg::result_type res);
      expected_results.insert(expected_results.size(), res);
   endfunction

   function automatic bit close_header(output wsfr_pkg::result_type res);
      res              = '0;
      res.frame_opcode = rx_opcode;
      res.last         = 1'b1;
      rx_key_index     = 2'd0;
      if (rx_opcode == wsfr_pkg::OP_TEXT) begin
         if (rx_remaining != '0) begin
            rx_phase = wsfr_pkg::PH_TEXT;
            return 1'b0;
         end
         rx_phase = wsfr_pkg::PH_HDR0;
         res.kind = wsfr_pkg::KIND_EMPTY;
      end else if (rx_opcode == wsfr_pkg::OP_CLOSE) begin
         rx_phase = wsfr_pkg::PH_CLOSED;
         res.kind = wsfr_pkg::KIND_CLOSE;
      end else begin
         rx_phase = (rx_remaining == '0) ? wsfr_pkg::PH_HDR0 : wsfr_pkg::PH_SKIP;
         res.kind = wsfr_pkg::KIND_OTHER;
      end
      return 1'b1;
   endfunction

   function automatic bit end_of_length(output wsfr_pkg::result_type res);
      res = '0;
      if (rx_masked) begin
         rx_field_count = wsfr_pkg::KEY_BYTES_M1;
         rx_key         = '0;
         rx_phase       = wsfr_pkg::PH_KEY;
         return 1'b0;
      end
      return close_header(res);
   endfunction

   function automatic bit parse_rx_byte(input logic [7:0] rx,
                                        output wsfr_pkg::result_type res);
      logic [7:0] key_byte;
      res = '0;
      case (rx_phase)
         wsfr_pkg::PH_HDR0: begin
            rx_opcode = rx[3:0];
            rx_phase  = wsfr_pkg::PH_HDR1;
         end
         wsfr_pkg::PH_HDR1: begin
            rx_masked    = rx[7];
            rx_key       = '0;
            rx_remaining = '0;
            if (rx[6:0] <= wsfr_pkg::LEN_DIRECT_MAX) begin
               rx_remaining[6:0] = rx[6:0];
               return end_of_length(res);
            end
            rx_field_count = (rx[6:0] == wsfr_pkg::LEN_EXT16) ? wsfr_pkg::EXT16_BYTES_M1
                                                              : wsfr_pkg::EXT64_BYTES_M1;
            rx_phase       = wsfr_pkg::PH_EXT;
         end
         wsfr_pkg::PH_EXT: begin
            rx_remaining = {rx_remaining[LB-9:0], rx};
            if (rx_field_count == 3'd0) return end_of_length(res);
            rx_field_count = rx_field_count - 3'd1;
         end
         wsfr_pkg::PH_KEY: begin
            rx_key = {rx_key[23:0], rx};
            if (rx_field_count == 3'd0) return close_header(res);
            rx_field_count = rx_field_count - 3'd1;
         end
         wsfr_pkg::PH_TEXT: begin
            key_byte         = rx_key[8 * (3 - int'(rx_key_index)) +: 8];
            rx_key_index     = rx_key_index + 2'd1;
            rx_remaining     = rx_remaining - {{(LB-1){1'b0}}, 1'b1};
            res.kind         = wsfr_pkg::KIND_BYTE;
            res.payload_byte = rx ^ key_byte;
            res.frame_opcode = rx_opcode;
            res.last         = (rx_remaining == '0);
            if (rx_remaining == '0) rx_phase = wsfr_pkg::PH_HDR0;
            return 1'b1;
         end
         wsfr_pkg::PH_SKIP: begin
            rx_remaining = rx_remaining - {{(LB-1){1'b0}}, 1'b1};
            if (rx_remaining == '0) rx_phase = wsfr_pkg::PH_HDR0;
         end
         wsfr_pkg::PH_CLOSED: begin
         end
         default: begin
            rx_phase = wsfr_pkg::PH_HDR0;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic send_rx_byte(input logic [7:0] rx);
      wsfr_pkg::result_type res;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      if (parse_rx_byte(rx, res)) queue_result(res);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [3:0] opcode, input bit masked,
                             input int unsigned len, input len_form_type form,
                             input logic [31:0] key);
      logic [63:0] ext_len;
      logic [6:0]  len_code;
      ext_len = 64'(len);
      case (form)
         LEN_FORM_EXT16: len_code = wsfr_pkg::LEN_EXT16;
         LEN_FORM_EXT64: len_code = wsfr_pkg::LEN_EXT64;
         default: len_code = len[6:0];
      endcase
      send_rx_byte({4'($urandom), opcode});
      send_rx_byte({masked, len_code});
      if (form == LEN_FORM_EXT16) begin
         send_rx_byte(ext_len[15:8]);
         send_rx_byte(ext_len[7:0]);
      end else if (form == LEN_FORM_EXT64) begin
         for (int i = 7; i >= 0; i--) send_rx_byte(ext_len[8 * i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_rx_byte(key[8 * i +: 8]);
      end
      for (int unsigned i = 0; i < len; i++) send_rx_byte(8'($urandom));
   endtask

   task automatic test_directed_frames();
      send_frame(wsfr_pkg::OP_TEXT, 1'b0, 0, LEN_FORM_DIRECT, 32'h0);
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 3, LEN_FORM_DIRECT, 32'hFFFF_FFFF);
      send_frame(wsfr_pkg::OP_TEXT, 1'b0, 2, LEN_FORM_EXT16, 32'h0);
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 0, LEN_FORM_EXT64, 32'h0);
      for (int op = 0; op < 16; op++) begin
         if (op != wsfr_pkg::OP_TEXT && op != wsfr_pkg::OP_CLOSE) begin
            send_frame(4'(op), 1'b0, 0, LEN_FORM_DIRECT, 32'h0);
         end
      end
      send_frame(4'h0, 1'b1, 4, LEN_FORM_EXT16, $urandom);
   endtask

   task automatic test_length_boundaries();
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 125, LEN_FORM_DIRECT, $urandom);
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 126, LEN_FORM_EXT16, $urandom);
      send_frame(wsfr_pkg::OP_TEXT, 1'b0, 3, LEN_FORM_EXT64, 32'h0);
   endtask

   task automatic test_backpressure();
      idle_on      = 1'b0;
      hold_request = 1'b1;
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 40, LEN_FORM_DIRECT, $urandom);
      idle_on      = 1'b1;
   endtask

   task automatic test_random_frames(input int unsigned count, input bit allow_idle);
      int unsigned  stop_at;
      int unsigned  len;
      logic [3:0]   opcode;
      len_form_type form;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         opcode  = wsfr_pkg::OP_TEXT;
         if ($urandom_range(0, 4) < 2) begin
            do opcode = 4'($urandom); while (opcode == wsfr_pkg::OP_CLOSE);
         end
         case ($urandom_range(0, 9))
            0: form = LEN_FORM_EXT16;
            1: form = LEN_FORM_EXT64;
            default: form = LEN_FORM_DIRECT;
         endcase
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
         if (form != LEN_FORM_DIRECT && $urandom_range(0, 9) == 0) len = $urandom_range(126, 300);
         send_frame(opcode, 1'($urandom), len, form, $urandom);
      end
   endtask

   // close is final: the parser ignores everything after it
   task automatic test_close_frame();
      send_frame(wsfr_pkg::OP_TEXT, 1'b1, 4, LEN_FORM_DIRECT, $urandom);
      send_frame(wsfr_pkg::OP_CLOSE, 1'b1, 3, LEN_FORM_DIRECT, $urandom);
      send_frame(wsfr_pkg::OP_TEXT, 1'b0, 5, LEN_FORM_DIRECT, 32'h0);
   endtask

   always @(posedge clock) begin : check_results
      wsfr_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected word: kind %0d payload_byte %h", rsp_kind, rsp_payload_byte);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %h, actual %h",
                         want.payload_byte, rsp_payload_byte);
                  error_count++;
               end
               if (rsp_frame_opcode !== want.frame_opcode) begin
                  $error("frame_opcode: expected %h, actual %h",
                         want.frame_opcode, rsp_frame_opcode);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, actual %b", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         else if (stall_left > 0) stall_left--;
         else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
         rsp_ready <= (hold_left == 0 && stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_length_boundaries();
      test_backpressure();
      test_random_frames(70, 1'b1);
      test_random_frames(30, 1'b0);
      test_close_frame();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
